FILE: rtl/core/morse_pulse_timing_decoder_assert.svh
// Assertion macros used by the decoder top-level RTL.
`ifndef MORSE_PULSE_TIMING_DECODER_ASSERT_SVH
`define MORSE_PULSE_TIMING_DECODER_ASSERT_SVH

`ifndef SYNTHESIS
// Checked on the rising clock edge, switched off while reset is high.
`define MPTD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on the rising clock edge, also during reset.
`define MPTD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MPTD_ASSERT(label, clk, rst, prop, msg)
`define MPTD_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

FILE: rtl/core/mptd_pkg.sv
`timescale 1ns / 1ps

package mptd_pkg;

   localparam int COUNT_BITS     = 16;
   localparam int CFG_BITS       = 16;
   localparam int LEN_BITS       = 16;
   localparam int CMP_BITS       = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic CMD_TICK   = 1'b0;
   localparam logic CMD_EDGE   = 1'b1;
   localparam logic LEVEL_RISE = 1'b1;

   typedef enum logic [2:0] {
      EV_START = 3'd0,
      EV_DOT   = 3'd1,
      EV_DASH  = 3'd2,
      EV_PAUSE = 3'd3,
      EV_END   = 3'd4
   } event_kind_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_DOT_MIN  = 3'd0,
      REG_DOT_MAX  = 3'd1,
      REG_DASH_MIN = 3'd2,
      REG_DASH_MAX = 3'd3,
      REG_GAP_MIN  = 3'd4,
      REG_GAP_MAX  = 3'd5
   } csr_index_type;

   localparam logic [CFG_BITS-1:0] DOT_MIN_RESET  = 16'd7032;
   localparam logic [CFG_BITS-1:0] DOT_MAX_RESET  = 16'd8594;
   localparam logic [CFG_BITS-1:0] DASH_MIN_RESET = 16'd14844;
   localparam logic [CFG_BITS-1:0] DASH_MAX_RESET = 16'd16407;
   localparam logic [CFG_BITS-1:0] GAP_MIN_RESET  = 16'd21000;
   localparam logic [CFG_BITS-1:0] GAP_MAX_RESET  = 16'd25000;

   typedef struct packed {
      logic [CFG_BITS-1:0] dot_min;
      logic [CFG_BITS-1:0] dot_max;
      logic [CFG_BITS-1:0] dash_min;
      logic [CFG_BITS-1:0] dash_max;
      logic [CFG_BITS-1:0] gap_min;
      logic [CFG_BITS-1:0] gap_max;
   } window_type;

   typedef struct packed {
      logic valid;
      logic cmd;
      logic level;
   } step_type;

   typedef struct packed {
      logic                valid;
      event_kind_type      kind;
      logic [LEN_BITS-1:0] len;
   } result_type;

   // Inclusive window test; a window with its minimum above its maximum never matches.
   function automatic logic in_window(input logic [CMP_BITS-1:0] v,
                                      input logic [CFG_BITS-1:0] lo,
                                      input logic [CFG_BITS-1:0] hi);
      return (v >= CMP_BITS'(lo)) && (v <= CMP_BITS'(hi));
   endfunction

endpackage

FILE: rtl/core/mptd_csr.sv
`timescale 1ns / 1ps

module mptd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [mptd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [mptd_pkg::CFG_BITS-1:0]       csr_wdata,
   output mptd_pkg::window_type                windows
);

   mptd_pkg::window_type win_ff;
   mptd_pkg::window_type win_in;

   always_comb begin
      win_in = win_ff;
      if (csr_we) begin
         case (mptd_pkg::csr_index_type'(csr_index))
            mptd_pkg::REG_DOT_MIN:  win_in.dot_min  = csr_wdata;
            mptd_pkg::REG_DOT_MAX:  win_in.dot_max  = csr_wdata;
            mptd_pkg::REG_DASH_MIN: win_in.dash_min = csr_wdata;
            mptd_pkg::REG_DASH_MAX: win_in.dash_max = csr_wdata;
            mptd_pkg::REG_GAP_MIN:  win_in.gap_min  = csr_wdata;
            mptd_pkg::REG_GAP_MAX:  win_in.gap_max  = csr_wdata;
            default: begin
               // Writes to unused indexes are dropped.
               win_in = win_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff.dot_min  <= mptd_pkg::DOT_MIN_RESET;
         win_ff.dot_max  <= mptd_pkg::DOT_MAX_RESET;
         win_ff.dash_min <= mptd_pkg::DASH_MIN_RESET;
         win_ff.dash_max <= mptd_pkg::DASH_MAX_RESET;
         win_ff.gap_min  <= mptd_pkg::GAP_MIN_RESET;
         win_ff.gap_max  <= mptd_pkg::GAP_MAX_RESET;
      end else begin
         win_ff <= win_in;
      end
   end

   assign windows = win_ff;

endmodule

FILE: rtl/core/mptd_core.sv
`timescale 1ns / 1ps

module mptd_core (
   input  logic                 clock,
   input  logic                 reset,
   input  mptd_pkg::step_type   step,
   input  mptd_pkg::window_type windows,
   output mptd_pkg::result_type result
);

   logic [mptd_pkg::COUNT_BITS-1:0] count_ff, count_in;
   logic                            awaiting_ff, awaiting_in;
   logic                            armed_ff, armed_in;
   logic                            seen_ff, seen_in;
   logic [mptd_pkg::CMP_BITS-1:0]   len_ext;

   assign len_ext = mptd_pkg::CMP_BITS'(count_ff);

   always_comb begin
      count_in    = count_ff;
      awaiting_in = awaiting_ff;
      armed_in    = armed_ff;
      seen_in     = seen_ff;
      result.valid = 1'b0;
      result.kind  = mptd_pkg::EV_START;
      result.len   = '0;
      if (step.valid) begin
         if (step.cmd == mptd_pkg::CMD_TICK) begin
            count_in = count_ff + mptd_pkg::COUNT_BITS'(1);
            // The counter wraps to zero on this tick.
            if ((count_ff == '1) && armed_ff) begin
               if (!seen_ff) begin
                  seen_in = 1'b1;
               end else begin
                  awaiting_in  = 1'b1;
                  armed_in     = 1'b0;
                  seen_in      = 1'b0;
                  result.valid = 1'b1;
                  result.kind  = mptd_pkg::EV_END;
               end
            end
         end else begin
            count_in = '0;
            if (step.level == mptd_pkg::LEVEL_RISE) begin
               if (awaiting_ff) begin
                  seen_in      = 1'b0;
                  armed_in     = 1'b1;
                  awaiting_in  = 1'b0;
                  result.valid = 1'b1;
                  result.kind  = mptd_pkg::EV_START;
               end else if (mptd_pkg::in_window(len_ext, windows.gap_min, windows.gap_max)) begin
                  result.valid = 1'b1;
                  result.kind  = mptd_pkg::EV_PAUSE;
                  result.len   = len_ext[mptd_pkg::LEN_BITS-1:0];
               end
            end else begin
               // The dot window takes priority where the two overlap.
               if (mptd_pkg::in_window(len_ext, windows.dot_min, windows.dot_max)) begin
                  result.valid = 1'b1;
                  result.kind  = mptd_pkg::EV_DOT;
                  result.len   = len_ext[mptd_pkg::LEN_BITS-1:0];
               end else if (mptd_pkg::in_window(len_ext, windows.dash_min,
                                                windows.dash_max)) begin
                  result.valid = 1'b1;
                  result.kind  = mptd_pkg::EV_DASH;
                  result.len   = len_ext[mptd_pkg::LEN_BITS-1:0];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         awaiting_ff <= 1'b1;
         armed_ff    <= 1'b0;
         seen_ff     <= 1'b0;
      end else begin
         count_ff    <= count_in;
         awaiting_ff <= awaiting_in;
         armed_ff    <= armed_in;
         seen_ff     <= seen_in;
      end
   end

endmodule

FILE: rtl/core/morse_pulse_timing_decoder.sv
`timescale 1ns / 1ps
// Morse pulse timing decoder.
// The req channel carries one item per transfer: req_tuser is the item kind
// (0 a prescaled timer tick, 1 a pin edge) and req_tdata[0] the pin level
// after an edge. The rsp channel carries events: rsp_tuser is the event kind
// (start, dot, dash, letter pause, end) and rsp_tdata the measured length.
// Ticks normally produce no event; edges produce one when a message starts or a window matches.
// The six window bounds are written through the csr port; the user must write them only
// while idle, as the block itself does not enforce it. An accepted item sits in the input
// register, is then classified against the tick counter and the windows, and its event is
// registered in the output register that drives rsp. One item can be accepted every cycle
// while the output register is empty or draining; the counter update and two window
// compares are the whole path. Reset restores the default windows, clears the counter and
// returns the decoder to waiting for a message. When rsp_tready is low the pending event
// holds, the input register still takes one more item, and req_tready drops only when
// both registers are full.
module morse_pulse_timing_decoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // [0] pin_level
   input  logic                                req_tuser,   // [0] cmd
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [mptd_pkg::LEN_BITS-1:0]       rsp_tdata,   // [15:0] pulse_length
   output logic [2:0]                          rsp_tuser,   // [2:0] event_kind
   input  logic                                csr_we,
   input  logic [mptd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [mptd_pkg::CFG_BITS-1:0]       csr_wdata
);

`include "morse_pulse_timing_decoder_assert.svh"

   logic                 in_valid_ff, in_valid_in;
   logic                 in_cmd_ff, in_cmd_in;
   logic                 in_level_ff, in_level_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   mptd_pkg::result_type rsp_data_ff, rsp_data_in;
   logic                 advance;
   logic                 req_xfer;
   mptd_pkg::step_type   step;
   mptd_pkg::window_type windows;
   mptd_pkg::result_type result;

   // The classify stage moves whenever the output register is empty or draining.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;

   assign step.valid = in_valid_ff && advance;
   assign step.cmd   = in_cmd_ff;
   assign step.level = in_level_ff;

   mptd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .windows   (windows)
   );

   mptd_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .windows (windows),
      .result  (result)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_cmd_in    = in_cmd_ff;
      in_level_in  = in_level_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
         in_cmd_in   = req_tuser;
         in_level_in = req_tdata[0];
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      if (advance) begin
         rsp_valid_in = result.valid;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_cmd_ff   <= in_cmd_in;
      in_level_ff <= in_level_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff.len;
   assign rsp_tuser  = rsp_data_ff.kind;

   `MPTD_ASSERT(a_start_end_zero_len, clock, reset, rsp_tvalid && ((rsp_tuser == mptd_pkg::EV_START) || (rsp_tuser == mptd_pkg::EV_END)) |-> (rsp_tdata == '0), "start or end event carries a non-zero length")
   `MPTD_ASSERT(a_input_held, clock, reset, in_valid_ff && !advance |=> in_valid_ff && $stable(in_cmd_ff) && $stable(in_level_ff), "stalled input item was lost or changed")
   `MPTD_ASSERT(a_ready_only_when_full, clock, reset, !req_tready |-> in_valid_ff && rsp_valid_ff, "input refused while a register was free")
   `MPTD_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_tvalid && req_tready, "pipeline not empty after reset")

endmodule

FILE: dv/morse_event_checker.sv
`timescale 1ns / 1ps

module morse_event_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // [0] pin_level
   input  logic                                req_tuser,   // [0] cmd
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [mptd_pkg::LEN_BITS-1:0]       rsp_tdata,   // [15:0] pulse_length
   input  logic [2:0]                          rsp_tuser,   // [2:0] event_kind
   input  logic                                csr_we,
   input  logic [mptd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [mptd_pkg::CFG_BITS-1:0]       csr_wdata,
   output int                                  mismatches,
   output int                                  events_pending
);

   import mptd_pkg::*;

   typedef struct packed {
      event_kind_type      kind;
      logic [LEN_BITS-1:0] pulse_len;
   } morse_event_type;

   morse_event_type expected_events[$];
   morse_event_type want;

   window_type            windows;
   logic [COUNT_BITS-1:0] ticks;
   logic                  awaiting;
   logic                  armed;
   logic                  wrapped_once;

   initial begin
      mismatches = 0;
      events_pending = 0;
   end

   task automatic report(input string what);
      $display("mismatch at %0t ns: %s", $time, what);
      mismatches++;
   endtask

   task automatic queue_event(input event_kind_type kind, input logic [COUNT_BITS-1:0] measured);
      morse_event_type ev;
      ev.kind = kind;
      ev.pulse_len = LEN_BITS'(measured);
      expected_events.push_back(ev);
   endtask

   function automatic logic fits_window(input logic [COUNT_BITS-1:0] measured,
                                        input logic [CFG_BITS-1:0] lo,
                                        input logic [CFG_BITS-1:0] hi);
      return (measured >= lo) && (measured <= hi);
   endfunction

   task automatic restore_defaults;
      windows.dot_min  = DOT_MIN_RESET;
      windows.dot_max  = DOT_MAX_RESET;
      windows.dash_min = DASH_MIN_RESET;
      windows.dash_max = DASH_MAX_RESET;
      windows.gap_min  = GAP_MIN_RESET;
      windows.gap_max  = GAP_MAX_RESET;
      ticks        = '0;
      awaiting     = 1'b1;
      armed        = 1'b0;
      wrapped_once = 1'b0;
      expected_events.delete();
   endtask

   // Works out the event, if any, that one accepted item causes.
   task automatic decode_item(input logic cmd, input logic level);
      logic [COUNT_BITS-1:0] measured;
      measured = ticks;
      if (cmd == CMD_TICK) begin
         ticks = ticks + COUNT_BITS'(1);
         // Only a wrap while a message is open matters; the second one closes it.
         if (ticks == '0 && armed) begin
            if (!wrapped_once) begin
               wrapped_once = 1'b1;
            end else begin
               armed        = 1'b0;
               wrapped_once = 1'b0;
               awaiting     = 1'b1;
               queue_event(EV_END, '0);
            end
         end
      end else if (level == LEVEL_RISE) begin
         ticks = '0;
         if (awaiting) begin
            awaiting     = 1'b0;
            armed        = 1'b1;
            wrapped_once = 1'b0;
            queue_event(EV_START, '0);
         end else if (fits_window(measured, windows.gap_min, windows.gap_max)) begin
            queue_event(EV_PAUSE, measured);
         end
      end else begin
         ticks = '0;
         if (fits_window(measured, windows.dot_min, windows.dot_max)) begin
            queue_event(EV_DOT, measured);
         end else if (fits_window(measured, windows.dash_min, windows.dash_max)) begin
            queue_event(EV_DASH, measured);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         restore_defaults();
      end else begin
         // A result can never belong to an item taken at the same edge, so check first.
         if (rsp_tvalid && rsp_tready) begin
            if (expected_events.size() == 0) begin
               report($sformatf("unexpected event kind %0d length %0d", rsp_tuser, rsp_tdata));
            end else begin
               want = expected_events.pop_front();
               if (rsp_tuser !== want.kind)
                  report($sformatf("event kind %0d, expected %0d", rsp_tuser, want.kind));
               if (rsp_tdata !== want.pulse_len)
                  report($sformatf("pulse length %0d, expected %0d", rsp_tdata,
                                   want.pulse_len));
            end
         end
         if (csr_we) begin
            case (csr_index)
               REG_DOT_MIN:  windows.dot_min  = csr_wdata;
               REG_DOT_MAX:  windows.dot_max  = csr_wdata;
               REG_DASH_MIN: windows.dash_min = csr_wdata;
               REG_DASH_MAX: windows.dash_max = csr_wdata;
               REG_GAP_MIN:  windows.gap_min  = csr_wdata;
               REG_GAP_MAX:  windows.gap_max  = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            decode_item(req_tuser, req_tdata[0]);
      end
      events_pending <= expected_events.size();
   end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;

   import mptd_pkg::*;

   localparam logic [CSR_INDEX_BITS-1:0] REG_UNUSED = 3'd7;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [7:0]                req_tdata  = '0;    // [0] pin_level
   logic                      req_tuser  = 1'b0;  // [0] cmd
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [LEN_BITS-1:0]       rsp_tdata;          // [15:0] pulse_length
   logic [2:0]                rsp_tuser;          // [2:0] event_kind
   logic                      csr_we     = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index  = '0;
   logic [CFG_BITS-1:0]       csr_wdata  = '0;

   int   mismatches;
   int   events_pending;
   int   items_sent = 0;
   logic calm = 1'b1;
   logic line_high = 1'b0;

   always #5 clock = ~clock;

   morse_pulse_timing_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   morse_event_checker events_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatches     (mismatches),
      .events_pending (events_pending)
   );

   // The padding bits above the pin level are randomised as well; the block must ignore them.
   task automatic send_item(input logic cmd, input logic level);
      logic [6:0] pad;
      pad = 7'($urandom);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {pad, level};
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send_item(CMD_TICK, 1'($urandom_range(0, 1)));
   endtask

   task automatic send_edge(input logic level);
      send_item(CMD_EDGE, level);
      line_high = level;
   endtask

   // Holds the sender until every outstanding event has gone, then lets the pipe empty.
   task automatic drain;
      req_tvalid <= 1'b0;
      do @(posedge clock); while (events_pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CFG_BITS-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic program_windows(input logic [CFG_BITS-1:0] dot_lo,
                                  input logic [CFG_BITS-1:0] dot_hi,
                                  input logic [CFG_BITS-1:0] dash_lo,
                                  input logic [CFG_BITS-1:0] dash_hi,
                                  input logic [CFG_BITS-1:0] gap_lo,
                                  input logic [CFG_BITS-1:0] gap_hi);
      write_reg(REG_DOT_MIN, dot_lo);
      write_reg(REG_DOT_MAX, dot_hi);
      write_reg(REG_DASH_MIN, dash_lo);
      write_reg(REG_DASH_MAX, dash_hi);
      write_reg(REG_GAP_MIN, gap_lo);
      write_reg(REG_GAP_MAX, gap_hi);
      if ($urandom_range(0, 1) == 0)
         write_reg(REG_UNUSED, CFG_BITS'($urandom));
      csr_we <= 1'b0;
   endtask

   task automatic program_random_windows;
      logic [CFG_BITS-1:0] dot_lo, dash_lo, gap_lo;
      if ($urandom_range(0, 3) == 0) begin
         // Unordered bounds, so empty windows and full-range ones turn up too.
         program_windows(CFG_BITS'($urandom_range(0, 24)),
                         ($urandom_range(0, 1) != 0) ? 16'hFFFF
                                                     : CFG_BITS'($urandom_range(0, 24)),
                         CFG_BITS'($urandom_range(0, 24)),
                         CFG_BITS'($urandom_range(0, 24)),
                         CFG_BITS'($urandom_range(0, 24)),
                         ($urandom_range(0, 1) != 0) ? 16'hFFFF
                                                     : CFG_BITS'($urandom_range(0, 24)));
      end else begin
         dot_lo  = CFG_BITS'($urandom_range(0, 8));
         dash_lo = CFG_BITS'($urandom_range(2, 16));
         gap_lo  = CFG_BITS'($urandom_range(0, 12));
         program_windows(dot_lo, dot_lo + CFG_BITS'($urandom_range(0, 6)),
                         dash_lo, dash_lo + CFG_BITS'($urandom_range(0, 8)),
                         gap_lo, gap_lo + CFG_BITS'($urandom_range(0, 10)));
      end
   endtask

   initial begin
      int seg;
      int seg_start;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset windows: a falling edge with no message open and nothing measured,
      // then a message start and a pulse too short for any window.
      send_edge(~LEVEL_RISE);
      send_edge(LEVEL_RISE);
      send_ticks(5);
      send_edge(~LEVEL_RISE);
      drain();

      // Extreme bounds: the dot window holds only the top count, so the full dash
      // window takes every short pulse, and only a zero gap counts as a pause.
      program_windows(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
      send_ticks(3);
      send_edge(~LEVEL_RISE);
      send_edge(LEVEL_RISE);
      send_edge(LEVEL_RISE);
      send_edge(~LEVEL_RISE);
      drain();

      // Overlapping dot and dash windows, a pulse outside all windows.
      program_windows(16'd2, 16'd4, 16'd3, 16'd8, 16'd5, 16'd9);
      send_ticks(3);
      send_edge(LEVEL_RISE);
      send_ticks(3);
      send_edge(~LEVEL_RISE);
      send_ticks(6);
      send_edge(LEVEL_RISE);
      send_ticks(1);
      send_edge(~LEVEL_RISE);
      send_ticks(8);
      send_edge(LEVEL_RISE);
      send_ticks(8);
      send_edge(~LEVEL_RISE);
      drain();

      // Every window with its minimum above its maximum.
      program_windows(16'd9, 16'd2, 16'd10, 16'd1, 16'd7, 16'd3);
      send_ticks(5);
      send_edge(LEVEL_RISE);
      send_ticks(5);
      send_edge(~LEVEL_RISE);

      // Random part: mostly alternating edges with short pulses, some stray ticks and edges.
      for (seg = 0; seg < 10; seg++) begin
         if (seg % 2 == 0) begin
            drain();
            program_random_windows();
         end
         calm = (seg >= 8) || ($urandom_range(0, 3) == 0);
         seg_start = items_sent;
         while (items_sent - seg_start < 50) begin
            if ($urandom_range(0, 4) != 0) begin
               send_ticks($urandom_range(0, 24));
               send_edge(!line_high);
            end else if ($urandom_range(0, 1) == 0) begin
               send_ticks($urandom_range(1, 6));
            end else begin
               send_edge(1'($urandom_range(0, 1)));
            end
         end
      end

      drain();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && events_pending == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

   initial begin
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      #20_000_000;
      $display("tb failed");
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/mptd_pkg.sv
rtl/core/mptd_csr.sv
rtl/core/mptd_core.sv
rtl/core/morse_pulse_timing_decoder.sv
dv/morse_event_checker.sv
dv/tb.sv
